### src/assert_macros.svh
// Assertion macros shared by the frame decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define RCFD_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("rcfd check failed");

// When ante holds, cons must hold at the same edge.
`define RCFD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rcfd check failed");

// When ante holds, cons must hold at the next edge.
`define RCFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rcfd check failed");

`endif

### src/rcfd_pkg.sv
// Types, constants and helper functions of the remote-control frame decoder.
`default_nettype none

package rcfd_pkg;

    // Frame geometry
    localparam int unsigned FRAME_LEN = 18;
    localparam int unsigned POS_W     = 5;
    localparam logic [POS_W-1:0] POS_IDLE = POS_W'(FRAME_LEN);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_LEN - 1);

    // Channel coding
    localparam int unsigned CHAN_W      = 11;
    localparam int unsigned LIMIT_W     = 10;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(660);
    localparam logic [CHAN_W-1:0]  CHAN_OFFSET = CHAN_W'(1024);

    // Frame queue between collector and decoder
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    typedef logic [7:0]                      t_byte;
    typedef logic [FRAME_LEN-1:0][7:0]       t_frame;
    typedef logic [CHAN_W-1:0]               t_chan;
    typedef logic [LIMIT_W-1:0]              t_limit;

    // Raw 11-bit channel to offset-removed two's complement pattern
    function automatic t_chan chan_bits(input t_chan raw);
        chan_bits = {~raw[CHAN_W-1], raw[CHAN_W-2:0]};
    endfunction

    // Magnitude of (raw - 1024)
    function automatic t_chan chan_mag(input t_chan raw);
        if (raw[CHAN_W-1]) begin
            chan_mag = {1'b0, raw[CHAN_W-2:0]};
        end else begin
            chan_mag = CHAN_OFFSET - {1'b0, raw[CHAN_W-2:0]};
        end
    endfunction

endpackage

`default_nettype wire

### src/rcfd_if.sv
// Valid/ready channel interfaces of the frame decoder: bytes in, frames, results out.
`default_nettype none

interface rcfd_byte_if import rcfd_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte rx_byte;
    logic  frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface rcfd_frame_if import rcfd_pkg::*; ();
    logic   valid;
    logic   ready;
    t_frame frame;

    modport source (output valid, output frame, input ready);
    modport sink   (input valid, input frame, output ready);
endinterface

interface rcfd_result_if import rcfd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic signed [10:0] stick_1;
    logic signed [10:0] stick_2;
    logic signed [10:0] stick_3;
    logic signed [10:0] stick_4;
    logic [1:0]         switch_one;
    logic [1:0]         switch_two;
    logic signed [15:0] mouse_x;
    logic signed [15:0] mouse_y;
    logic signed [15:0] mouse_z;
    logic [15:0]        mouse_buttons;
    logic [15:0]        key_mask;
    logic signed [10:0] wheel;

    modport source (output valid, output stick_1, output stick_2, output stick_3,
                    output stick_4, output switch_one, output switch_two,
                    output mouse_x, output mouse_y, output mouse_z,
                    output mouse_buttons, output key_mask, output wheel,
                    input ready);
    modport sink   (input valid, input stick_1, input stick_2, input stick_3,
                    input stick_4, input switch_one, input switch_two,
                    input mouse_x, input mouse_y, input mouse_z,
                    input mouse_buttons, input key_mask, input wheel,
                    output ready);
endinterface

`default_nettype wire

### src/rcfd_front.sv
// Front end: accepts receiver bytes, tracks position in the frame, emits complete frames.
`default_nettype none
`include "assert_macros.svh"

module rcfd_front import rcfd_pkg::*; (
    input  wire           i_clk,
    input  wire           i_rst_n,
    rcfd_byte_if.sink     i_in,
    rcfd_frame_if.source  o_frame
);

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    t_byte            r_bytes [FRAME_LEN-1];
    logic             w_accept;
    logic             w_last;

    // A byte is taken only while the queue can hold a finished frame
    assign i_in.ready = o_frame.ready;
    assign w_accept   = i_in.valid & i_in.ready;
    assign w_last     = ~i_in.frame_start & (r_pos == POS_LAST);

    // Completed frame goes straight to the queue with the final byte
    assign o_frame.valid = w_accept & w_last;
    always_comb begin
        for (int k = 0; k < FRAME_LEN - 1; k++) begin
            o_frame.frame[k] = r_bytes[k];
        end
        o_frame.frame[FRAME_LEN-1] = i_in.rx_byte;
    end

    // Position tracking: start restarts, idle ignores, last byte closes
    always_comb begin
        n_pos = r_pos;
        if (w_accept) begin
            priority if (i_in.frame_start) begin
                n_pos = POS_W'(1);
            end else if (r_pos < POS_IDLE) begin
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_IDLE;
        end else begin
            r_pos <= n_pos;
        end
    end

    // Byte store, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            priority if (i_in.frame_start) begin
                r_bytes[0] <= i_in.rx_byte;
            end else if (r_pos < POS_LAST) begin
                r_bytes[r_pos] <= i_in.rx_byte;
            end
        end
    end

    `RCFD_ASSERT_ALWAYS(a_pos_range, r_pos <= POS_IDLE)
    `RCFD_ASSERT_NEXT(a_push_idles, o_frame.valid, r_pos == POS_IDLE)

endmodule

`default_nettype wire

### src/rcfd_queue.sv
// Short frame queue decoupling the byte collector from the decoder.
`default_nettype none
`include "assert_macros.svh"

module rcfd_queue import rcfd_pkg::*; (
    input  wire           i_clk,
    input  wire           i_rst_n,
    rcfd_frame_if.sink    i_push,
    rcfd_frame_if.source  o_pop
);

    t_frame            r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_push;
    logic              w_pop;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign i_push.ready = (r_count != QCNT_W'(QDEPTH));
    assign o_pop.valid  = (r_count != '0);
    assign o_pop.frame  = r_mem[r_rd_ptr];
    assign w_push       = i_push.valid & i_push.ready;
    assign w_pop        = o_pop.valid & o_pop.ready;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (w_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            unique case ({w_push, w_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // Frame storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push.frame;
        end
    end

    `RCFD_ASSERT_ALWAYS(a_count_bound, r_count <= QCNT_W'(QDEPTH))
    `RCFD_ASSERT_NEXT(a_count_up, w_push && !w_pop, r_count == $past(r_count) + QCNT_W'(1))

endmodule

`default_nettype wire

### src/rcfd_back.sv
// Back end: decodes a queued frame, applies the stick limit, holds the result register.
`default_nettype none
`include "assert_macros.svh"

module rcfd_back import rcfd_pkg::*; (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_cfg_we,
    input  wire [LIMIT_W-1:0] i_cfg_wdata,
    rcfd_frame_if.sink      i_frame,
    rcfd_result_if.source   o_out
);

    t_limit r_limit;
    logic   r_valid;
    logic   w_pop;
    logic   w_bad;
    t_chan  w_raw [4];
    t_frame f;

    // Stick limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    // Unpack the four packed stick channels
    assign f = i_frame.frame;
    assign w_raw[0] = {f[1][2:0], f[0]};
    assign w_raw[1] = {f[2][5:0], f[1][7:3]};
    assign w_raw[2] = {f[4][0], f[3], f[2][7:6]};
    assign w_raw[3] = {f[5][3:0], f[4][7:1]};

    // Any stick beyond the limit invalidates sticks and switches
    always_comb begin
        w_bad = 1'b0;
        for (int k = 0; k < 4; k++) begin
            if (chan_mag(w_raw[k]) > {1'b0, r_limit}) begin
                w_bad = 1'b1;
            end
        end
    end

    // Result register refills when empty or being drained
    assign w_pop         = i_frame.valid & (~r_valid | o_out.ready);
    assign i_frame.ready = ~r_valid | o_out.ready;
    assign o_out.valid   = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            o_out.stick_1       <= w_bad ? '0 : chan_bits(w_raw[0]);
            o_out.stick_2       <= w_bad ? '0 : chan_bits(w_raw[1]);
            o_out.stick_3       <= w_bad ? '0 : chan_bits(w_raw[2]);
            o_out.stick_4       <= w_bad ? '0 : chan_bits(w_raw[3]);
            o_out.switch_one    <= w_bad ? 2'b00 : f[5][7:6];
            o_out.switch_two    <= w_bad ? 2'b00 : f[5][5:4];
            o_out.mouse_x       <= {f[7], f[6]};
            o_out.mouse_y       <= {f[9], f[8]};
            o_out.mouse_z       <= {f[11], f[10]};
            o_out.mouse_buttons <= {f[13], f[12]};
            o_out.key_mask      <= {f[15], f[14]};
            o_out.wheel         <= chan_bits({f[17][2:0], f[16]});
        end
    end

    `RCFD_ASSERT_NEXT(a_bad_zeroes, w_pop && w_bad, o_out.stick_1 == '0 && o_out.stick_2 == '0 && o_out.stick_3 == '0 && o_out.stick_4 == '0 && o_out.switch_one == 2'b00 && o_out.switch_two == 2'b00)
    `RCFD_ASSERT_NEXT(a_pop_fills, w_pop, r_valid)

endmodule

`default_nettype wire

### src/rc_frame_decoder.sv
// Top level of the remote-control receiver frame decoder.
`default_nettype none

// Takes one receiver byte per cycle on i_in (frame_start marks byte 0) and,
// once 18 bytes of a frame are in, delivers one decoded result on o_out
// after the frame has passed through the frame queue and then the result
// register. Sustained rate is one byte per clock; i_in.ready drops
// only when the two-entry frame queue is full because o_out is stalled.
// A new start flag drops a partial frame; bytes while idle are ignored.
// i_cfg_we/i_cfg_wdata write the 10-bit stick limit (reset 660); write it
// only while no frame is in flight.
module rc_frame_decoder import rcfd_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire [LIMIT_W-1:0] i_cfg_wdata,
    rcfd_byte_if.sink         i_in,
    rcfd_result_if.source     o_out
);

    rcfd_frame_if u_q_in  ();
    rcfd_frame_if u_q_out ();

    // Byte collection
    rcfd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_frame (u_q_in)
    );

    // Frame queue
    rcfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (u_q_in),
        .o_pop   (u_q_out)
    );

    // Decode and output register
    rcfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_frame     (u_q_out),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
